/* src/conv2d_valid_cross_correlation_top_macros.svh */
// Assertion macros shared by the conv2d cross-correlation RTL.
// Included by the modules that check their own logic; no other dependencies.
`ifndef CONV2D_VALID_CROSS_CORRELATION_TOP_MACROS_SVH
`define CONV2D_VALID_CROSS_CORRELATION_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Hold a condition at every clock edge.
`define C2D_ASSERT_ALWAYS(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// Same-cycle implication.
`define C2D_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define C2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define C2D_ASSERT_ALWAYS(lbl, clk, rst, expr, msg)
`define C2D_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define C2D_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

/* src/c2d_pkg.sv */
// Shared widths, codes and beat types for the conv2d cross-correlation block.
// No dependencies; imported by the top level, the window cell and the result FIFO.
`timescale 1ns / 1ps
`default_nettype none

package c2d_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int ADDEND_W     = 40;
   localparam int VALUE_W      = 41;
   localparam int ROW_W        = 12;
   localparam int COL_W        = 10;
   localparam int WIDX_W       = 4;
   localparam int PROD_W       = 2 * SAMPLE_W;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int MAX_HEIGHT   = 4096;
   localparam int SIZE_RESET   = 32;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   localparam int FIFO_DEPTH   = 8;
   localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = CSR_INDEX_W'(1);

   localparam logic MODE_WEIGHT = 1'b0;
   localparam logic MODE_PIXEL  = 1'b1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // Per-pixel bookkeeping that rides alongside the datapath.
   typedef struct packed {
      logic                       produce;
      logic signed [ADDEND_W-1:0] addend;
      logic [ROW_W-1:0]           row;
      logic [COL_W-1:0]           col;
      logic                       last;
   } meta_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [ROW_W-1:0]          row;
      logic [COL_W-1:0]          col;
      logic                      last;
   } result_type;

endpackage

`default_nettype wire

/* src/conv2d_valid_cross_correlation_top.sv */
// Top level of the streaming valid 2D cross-correlation block.
// Depends on c2d_pkg, c2d_line_store, c2d_win_cell, c2d_out_fifo and the macros header.
//
// Usage:
//   req_ beats carry either a kernel weight (req_mode 0, placed at req_weight_index)
//   or one image pixel in raster order (req_mode 1) with the addend for the window
//   that ends at that pixel. A beat is taken on a clock edge with req_valid high
//   and req_stall low.
//   rsp_ beats carry one result for each window that fits inside the image: addend
//   plus the exact weighted sum, the window's top-left row and column, and a flag
//   on the final window of the image. A beat is taken with rsp_valid high and
//   rsp_stall low.
//   csr_ writes set image_width (index 0) and image_height (index 1); csr_ready
//   is always high. Write them only while the block is idle.
// Throughput: one beat per cycle while req_stall is low, bounded by the single read and single write
//   port of the line store that every pixel uses.
// Path: a pixel's result passes the registered line store read, the product and column sum
//   registers, then the final add into the result FIFO that drives rsp_.
// Reset: clears weights, window, counters, credits, pipeline tags and result FIFO; size
//   registers return to 32 by 32. The line store is left as it is.
// Stall: results queue in an 8-deep FIFO; req_stall rises once every slot is
//   claimed by a queued or in-flight result, and drops as rsp_ beats drain.
`timescale 1ns / 1ps
`default_nettype none

`include "conv2d_valid_cross_correlation_top_macros.svh"

module conv2d_valid_cross_correlation_top
   import c2d_pkg::*;
#(
   parameter int KERNEL    = 3,
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,

   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_mode,
   input  wire logic [WIDX_W-1:0]          req_weight_index,
   input  wire logic signed [SAMPLE_W-1:0] req_sample_value,
   input  wire logic signed [ADDEND_W-1:0] req_addend,

   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]       rsp_out_value,
   output logic [ROW_W-1:0]                rsp_out_row,
   output logic [COL_W-1:0]                rsp_out_col,
   output logic                            rsp_last_output,

   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata
);

   localparam int TAPS        = KERNEL * KERNEL;
   localparam int CW          = $clog2(MAX_WIDTH);
   localparam int WEFF_W      = $clog2(MAX_WIDTH + 1);
   localparam int WIDTH_RESET = (MAX_WIDTH < SIZE_RESET) ? MAX_WIDTH : SIZE_RESET;
   localparam int LINE_ROWS   = (KERNEL > 1) ? KERNEL - 1 : 1;
   localparam int LINE_W      = LINE_ROWS * SAMPLE_W;
   localparam int CSUM_W      = PROD_W + $clog2(KERNEL);

   // ---------------------------------------------------------------------------
   // Size registers, held already clamped: zero reads as one, oversize saturates.
   // ---------------------------------------------------------------------------
   logic [WEFF_W-1:0]       width_eff_ff,  width_eff_in;
   logic [HEIGHT_REG_W-1:0] height_eff_ff, height_eff_in;
   logic [WIDTH_REG_W-1:0]  csr_width;
   logic [HEIGHT_REG_W-1:0] csr_height;

   assign csr_ready  = 1'b1;
   assign csr_width  = csr_wdata[WIDTH_REG_W-1:0];
   assign csr_height = csr_wdata[HEIGHT_REG_W-1:0];

   always_comb begin
      width_eff_in  = width_eff_ff;
      height_eff_in = height_eff_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_IMAGE_WIDTH: begin
               if (csr_width == '0) begin
                  width_eff_in = WEFF_W'(1);
               end else if (32'(csr_width) > MAX_WIDTH) begin
                  width_eff_in = WEFF_W'(MAX_WIDTH);
               end else begin
                  width_eff_in = WEFF_W'(csr_width);
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_height == '0) begin
                  height_eff_in = HEIGHT_REG_W'(1);
               end else if (32'(csr_height) > MAX_HEIGHT) begin
                  height_eff_in = HEIGHT_REG_W'(MAX_HEIGHT);
               end else begin
                  height_eff_in = csr_height;
               end
            end
            default: begin
               // drop writes to unused indexes
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_eff_ff  <= WEFF_W'(WIDTH_RESET);
         height_eff_ff <= HEIGHT_REG_W'(SIZE_RESET);
      end else begin
         width_eff_ff  <= width_eff_in;
         height_eff_ff <= height_eff_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Input acceptance and result credits. Every result that is in flight or
   // queued holds one FIFO slot, so the FIFO can never overflow.
   // ---------------------------------------------------------------------------
   logic               req_accept;
   logic               pix_accept;
   logic               wgt_accept;
   logic               rsp_pop;
   logic               produce;
   logic [FIFO_CW-1:0] credit_ff, credit_in;

   assign req_accept = req_valid && !req_stall;
   assign pix_accept = req_accept && (req_mode == MODE_PIXEL);
   assign wgt_accept = req_accept && (req_mode == MODE_WEIGHT);
   assign rsp_pop    = rsp_valid && !rsp_stall;
   assign req_stall  = (credit_ff == FIFO_CW'(FIFO_DEPTH));

   always_comb begin
      credit_in = credit_ff;
      if (pix_accept && produce && !rsp_pop) begin
         credit_in = FIFO_CW'(credit_ff + 1'b1);
      end else if (rsp_pop && !(pix_accept && produce)) begin
         credit_in = FIFO_CW'(credit_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Kernel weights, row-major; out-of-range indexes are dropped.
   // ---------------------------------------------------------------------------
   sample_type weights_ff [TAPS];
   sample_type weights_in [TAPS];

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         weights_in[i] = weights_ff[i];
         if (wgt_accept && (32'(req_weight_index) == i)) begin
            weights_in[i] = req_sample_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TAPS; i++) begin
            weights_ff[i] <= '0;
         end
      end else begin
         for (int i = 0; i < TAPS; i++) begin
            weights_ff[i] <= weights_in[i];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Raster counters. A column or row left past a shrunk size wraps at once.
   // ---------------------------------------------------------------------------
   logic [CW-1:0]    column_count_ff, column_count_in;
   logic [ROW_W-1:0] row_count_ff,    row_count_in;
   logic             col_wrap;
   logic             row_wrap;

   assign col_wrap = (32'(column_count_ff) + 1) >= 32'(width_eff_ff);
   assign row_wrap = (32'(row_count_ff) + 1) >= 32'(height_eff_ff);
   assign produce  = (32'(column_count_ff) >= KERNEL - 1) && (32'(row_count_ff) >= KERNEL - 1);

   always_comb begin
      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (pix_accept) begin
         if (col_wrap) begin
            column_count_in = '0;
            row_count_in    = row_wrap ? '0 : ROW_W'(32'(row_count_ff) + 1);
         end else begin
            column_count_in = CW'(32'(column_count_ff) + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: line store read issued at accept; hold the pixel and its tags.
   // ---------------------------------------------------------------------------
   logic          s1_pix_ff;
   sample_type    s1_sample_ff;
   logic [CW-1:0] s1_addr_ff;
   meta_type      s1_meta_ff, s1_meta_in;
   meta_type      s2_meta_ff;
   meta_type      s3_meta_ff;

   always_comb begin
      s1_meta_in.produce = pix_accept && produce;
      s1_meta_in.addend  = req_addend;
      s1_meta_in.row     = ROW_W'(32'(row_count_ff) - (KERNEL - 1));
      s1_meta_in.col     = COL_W'(32'(column_count_ff) - (KERNEL - 1));
      s1_meta_in.last    = col_wrap && row_wrap;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_pix_ff  <= 1'b0;
         s1_meta_ff <= '0;
         s2_meta_ff <= '0;
         s3_meta_ff <= '0;
      end else begin
         s1_pix_ff  <= pix_accept;
         s1_meta_ff <= s1_meta_in;
         s2_meta_ff <= s1_meta_ff;
         s3_meta_ff <= s2_meta_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_sample_ff <= req_sample_value;
         s1_addr_ff   <= column_count_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Line store: row k of a column gets row k+1, the newest row gets the pixel.
   // ---------------------------------------------------------------------------
   logic [LINE_W-1:0] line_rd;
   logic [LINE_W-1:0] line_wdata;
   sample_type        new_col [KERNEL];

   always_comb begin
      for (int k = 0; k < LINE_ROWS; k++) begin
         if (k + 1 < LINE_ROWS) begin
            line_wdata[k*SAMPLE_W +: SAMPLE_W] = line_rd[(k+1)*SAMPLE_W +: SAMPLE_W];
         end else begin
            line_wdata[k*SAMPLE_W +: SAMPLE_W] = s1_sample_ff;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < KERNEL; k++) begin
         if (k < KERNEL - 1) begin
            new_col[k] = sample_type'(line_rd[k*SAMPLE_W +: SAMPLE_W]);
         end else begin
            new_col[k] = s1_sample_ff;
         end
      end
   end

   c2d_line_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .DW    (LINE_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (pix_accept),
      .rd_addr (column_count_ff),
      .rd_data (line_rd),
      .wr_en   (s1_pix_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (line_wdata)
   );

   // ---------------------------------------------------------------------------
   // Stages 2 and 3: chain of window cells, one per kernel column. The new
   // column enters at the right end; each cell hands its column leftward.
   // ---------------------------------------------------------------------------
   sample_type               win_col [KERNEL][KERNEL];
   sample_type               cell_w  [KERNEL][KERNEL];
   logic signed [CSUM_W-1:0] colsum  [KERNEL];

   for (genvar l = 0; l < KERNEL; l++) begin : g_cell
      for (genvar k = 0; k < KERNEL; k++) begin : g_w
         assign cell_w[l][k] = weights_ff[k*KERNEL + l];
      end

      if (l == KERNEL - 1) begin : g_tail
         c2d_win_cell #(
            .KERNEL (KERNEL)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (s1_pix_ff),
            .col_in     (new_col),
            .weight     (cell_w[l]),
            .col_out    (win_col[l]),
            .colsum_out (colsum[l])
         );
      end else begin : g_body
         c2d_win_cell #(
            .KERNEL (KERNEL)
         ) u_cell (
            .clock      (clock),
            .reset      (reset),
            .shift_en   (s1_pix_ff),
            .col_in     (win_col[l+1]),
            .weight     (cell_w[l]),
            .col_out    (win_col[l]),
            .colsum_out (colsum[l])
         );
      end
   end

   // ---------------------------------------------------------------------------
   // Final add of the addend and the column sums, then into the result FIFO.
   // ---------------------------------------------------------------------------
   logic signed [VALUE_W-1:0] sum_value;
   result_type                push_data;
   result_type                rsp_data;

   always_comb begin
      sum_value = VALUE_W'(s3_meta_ff.addend);
      for (int l = 0; l < KERNEL; l++) begin
         sum_value = sum_value + VALUE_W'(colsum[l]);
      end
   end

   always_comb begin
      push_data.value = sum_value;
      push_data.row   = s3_meta_ff.row;
      push_data.col   = s3_meta_ff.col;
      push_data.last  = s3_meta_ff.last;
   end

   c2d_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (s3_meta_ff.produce),
      .push_data (push_data),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_value   = rsp_data.value;
   assign rsp_out_row     = rsp_data.row;
   assign rsp_out_col     = rsp_data.col;
   assign rsp_last_output = rsp_data.last;

   `C2D_ASSERT_ALWAYS(a_credit_bound, clock, reset, credit_ff <= FIFO_CW'(FIFO_DEPTH), "result credits above fifo depth")
   `C2D_ASSERT_NEXT(a_load_no_credit, clock, reset, wgt_accept && !rsp_pop, credit_ff == $past(credit_ff), "weight load changed credits")
   `C2D_ASSERT_NEXT(a_col_wrap, clock, reset, pix_accept && col_wrap, column_count_ff == '0, "column did not wrap at row end")
   `C2D_ASSERT_IMPLY(a_produce_pixel, clock, reset, s1_meta_ff.produce, s1_pix_ff, "result tagged on a non-pixel beat")

endmodule

`default_nettype wire

/* src/c2d_line_store.sv */
// Line store memory: one read and one write port, registered read with write forwarding.
// Uses no package items.
`timescale 1ns / 1ps
`default_nettype none

module c2d_line_store #(
   parameter int DEPTH = 1024,
   parameter int AW    = 10,
   parameter int DW    = 32
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic [DW-1:0]      rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      // forward a same-cycle write so a one-pixel row reads its newest data
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/c2d_win_cell.sv */
// One window column cell: holds KERNEL pixels, shifts to its left neighbor,
// multiplies by its weight column and sums. Depends on c2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module c2d_win_cell
   import c2d_pkg::*;
#(
   parameter int KERNEL = 3
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       shift_en,
   input  wire sample_type col_in  [KERNEL],
   input  wire sample_type weight  [KERNEL],
   output sample_type      col_out [KERNEL],
   output logic signed [PROD_W+$clog2(KERNEL)-1:0] colsum_out
);

   localparam int CSUM_W = PROD_W + $clog2(KERNEL);

   sample_type                win_ff   [KERNEL];
   sample_type                win_in   [KERNEL];
   logic signed [PROD_W-1:0]  prod_ff  [KERNEL];
   logic signed [CSUM_W-1:0]  colsum_ff;
   logic signed [CSUM_W-1:0]  colsum_in;

   always_comb begin
      for (int k = 0; k < KERNEL; k++) begin
         win_in[k] = shift_en ? col_in[k] : win_ff[k];
      end
   end

   always_comb begin
      colsum_in = '0;
      for (int k = 0; k < KERNEL; k++) begin
         colsum_in = colsum_in + CSUM_W'(prod_ff[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KERNEL; k++) begin
            win_ff[k] <= '0;
         end
      end else begin
         for (int k = 0; k < KERNEL; k++) begin
            win_ff[k] <= win_in[k];
         end
      end
   end

   // products see the window as it stands after this beat's shift
   always_ff @(posedge clock) begin
      for (int k = 0; k < KERNEL; k++) begin
         prod_ff[k] <= win_in[k] * weight[k];
      end
      colsum_ff <= colsum_in;
   end

   assign col_out    = win_ff;
   assign colsum_out = colsum_ff;

endmodule

`default_nettype wire

/* src/c2d_out_fifo.sv */
// Result FIFO that decouples the datapath from the rsp_ stall.
// Depends on c2d_pkg and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "conv2d_valid_cross_correlation_top_macros.svh"

module c2d_out_fifo
   import c2d_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   input  wire logic       rsp_stall,
   output logic            rsp_valid,
   output result_type      rsp_data
);

   result_type           entries_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff;
   logic [FIFO_AW-1:0]   rd_ptr_ff;
   logic [FIFO_CW-1:0]   count_ff;
   logic                 pop;

   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_data  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= FIFO_AW'(wr_ptr_ff + 1'b1);
         end
         if (pop) begin
            rd_ptr_ff <= FIFO_AW'(rd_ptr_ff + 1'b1);
         end
         if (push && !pop) begin
            count_ff <= FIFO_CW'(count_ff + 1'b1);
         end else if (pop && !push) begin
            count_ff <= FIFO_CW'(count_ff - 1'b1);
         end
      end
   end

   `C2D_ASSERT_ALWAYS(a_fifo_bound, clock, reset,
                      count_ff <= FIFO_CW'(FIFO_DEPTH), "fifo count above depth")
   `C2D_ASSERT_IMPLY(a_fifo_no_overflow, clock, reset, push && !pop,
                     count_ff != FIFO_CW'(FIFO_DEPTH), "push into full fifo")
   `C2D_ASSERT_NEXT(a_fifo_drain, clock, reset, pop && !push,
                    count_ff == FIFO_CW'($past(count_ff) - 1'b1), "pop did not drain fifo")

endmodule

`default_nettype wire
